>>> src/ad32_pkg.sv
`default_nettype none

package ad32_pkg;

   localparam int unsigned DATA_W       = 64;
   localparam int unsigned COUNT_W      = 4;
   localparam int unsigned HALF_W       = 16;
   localparam int unsigned SUM_PLAIN_W  = 11;
   localparam int unsigned SUM_WEIGHT_W = 14;
   localparam int unsigned PROD_W       = 12;
   localparam int unsigned WIDE_B_W     = 20;

   localparam logic [HALF_W-1:0] ADLER_MOD = 16'd65521;
   localparam logic [HALF_W-1:0] FOLD_K    = 16'd15;

   typedef struct packed {
      logic [DATA_W-1:0]  data_bytes;
      logic [COUNT_W-1:0] byte_count;
      logic               start_flag;
   } req_type;

   typedef struct packed {
      logic [31:0]       checksum;
      logic [DATA_W-1:0] data_echo;
   } rsp_type;

   typedef struct packed {
      logic [SUM_PLAIN_W-1:0]  sum_plain;
      logic [SUM_WEIGHT_W-1:0] sum_weighted;
      logic [COUNT_W-1:0]      count;
      logic                    start;
      logic [DATA_W-1:0]       data;
   } part_type;

   function automatic logic [HALF_W-1:0] reduce_once(input logic [HALF_W:0] value);
      logic [HALF_W:0] diff;
      diff = value - {1'b0, ADLER_MOD};
      if (value >= {1'b0, ADLER_MOD}) begin
         return diff[HALF_W-1:0];
      end
      return value[HALF_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/ad32_lane.sv
`default_nettype none

module ad32_lane #(
   parameter int unsigned LANE_INDEX = 0
) (
   input  wire logic [7:0]                       lane_byte,
   input  wire logic [ad32_pkg::COUNT_W-1:0]     lane_count,
   output logic      [7:0]                       lane_plain,
   output logic      [ad32_pkg::PROD_W-1:0]      lane_weighted
);

   logic                            active;
   logic [ad32_pkg::COUNT_W-1:0]    weight;

   // A byte at position j is added to B once for itself and once for each later byte.
   assign active        = lane_count > ad32_pkg::COUNT_W'(LANE_INDEX);
   assign weight        = lane_count - ad32_pkg::COUNT_W'(LANE_INDEX);
   assign lane_plain    = active ? lane_byte : 8'd0;
   assign lane_weighted = active ? (ad32_pkg::PROD_W'(weight) * ad32_pkg::PROD_W'(lane_byte))
                                 : '0;

endmodule

`default_nettype wire

>>> src/ad32_lanes.sv
`default_nettype none

module ad32_lanes #(
   parameter int unsigned NUM_LANES = 8
) (
   input  wire logic               clock,
   input  wire logic               load_en,
   input  wire ad32_pkg::req_type  req_payload,
   output ad32_pkg::part_type      part
);

   logic [ad32_pkg::COUNT_W-1:0]      count_sat;
   logic [7:0]                        plain_bytes [NUM_LANES];
   logic [ad32_pkg::PROD_W-1:0]       weighted_bytes [NUM_LANES];
   logic [ad32_pkg::SUM_PLAIN_W-1:0]  acc_plain;
   logic [ad32_pkg::SUM_WEIGHT_W-1:0] acc_weighted;
   ad32_pkg::part_type                part_ff;
   ad32_pkg::part_type                part_in;

   assign count_sat = (req_payload.byte_count > ad32_pkg::COUNT_W'(NUM_LANES))
                      ? ad32_pkg::COUNT_W'(NUM_LANES) : req_payload.byte_count;

   for (genvar j = 0; j < NUM_LANES; j++) begin : g_lane
      ad32_lane #(
         .LANE_INDEX (j)
      ) u_lane (
         .lane_byte     (req_payload.data_bytes[8*j +: 8]),
         .lane_count    (count_sat),
         .lane_plain    (plain_bytes[j]),
         .lane_weighted (weighted_bytes[j])
      );
   end

   always_comb begin
      acc_plain    = '0;
      acc_weighted = '0;
      for (int j = 0; j < NUM_LANES; j++) begin
         acc_plain    = acc_plain + ad32_pkg::SUM_PLAIN_W'(plain_bytes[j]);
         acc_weighted = acc_weighted + ad32_pkg::SUM_WEIGHT_W'(weighted_bytes[j]);
      end
      part_in.sum_plain    = acc_plain;
      part_in.sum_weighted = acc_weighted;
      part_in.count        = count_sat;
      part_in.start        = req_payload.start_flag;
      part_in.data         = req_payload.data_bytes;
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         part_ff <= part_in;
      end
   end

   assign part = part_ff;

endmodule

`default_nettype wire

>>> src/ad32_state.sv
`default_nettype none

module ad32_state (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load_en,
   input  wire ad32_pkg::part_type  part,
   input  wire logic [31:0]         seed,
   output ad32_pkg::rsp_type        rsp_payload
);

   localparam int unsigned HW = ad32_pkg::HALF_W;
   localparam int unsigned BW = ad32_pkg::WIDE_B_W;

   logic [HW-1:0]     sum_a_ff;
   logic [HW-1:0]     sum_a_in;
   logic [HW-1:0]     sum_b_ff;
   logic [HW-1:0]     sum_b_in;
   ad32_pkg::rsp_type rsp_ff;
   ad32_pkg::rsp_type rsp_in;

   logic [HW-1:0]     base_a;
   logic [HW-1:0]     base_b;
   logic [HW:0]       a_raw;
   logic [BW-1:0]     scaled_a;
   logic [BW-1:0]     b_raw;
   logic [HW:0]       b_fold;

   // B grows by count times the old A plus the position-weighted bytes.
   // The wide sum stays below 2^20; 2^16 is 15 modulo 65521, so one fold
   // and one subtraction finish the reduction.
   always_comb begin
      base_a   = part.start ? ad32_pkg::reduce_once({1'b0, seed[HW-1:0]}) : sum_a_ff;
      base_b   = part.start ? ad32_pkg::reduce_once({1'b0, seed[2*HW-1:HW]}) : sum_b_ff;
      a_raw    = {1'b0, base_a} + (HW+1)'(part.sum_plain);
      sum_a_in = ad32_pkg::reduce_once(a_raw);
      scaled_a = BW'(part.count) * BW'(base_a);
      b_raw    = BW'(base_b) + scaled_a + BW'(part.sum_weighted);
      b_fold   = {1'b0, b_raw[HW-1:0]}
                 + (HW+1)'(b_raw[BW-1:HW]) * (HW+1)'(ad32_pkg::FOLD_K);
      sum_b_in = ad32_pkg::reduce_once(b_fold);
      rsp_in.checksum  = {sum_b_in, sum_a_in};
      rsp_in.data_echo = part.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= 16'd1;
         sum_b_ff <= 16'd0;
      end else if (load_en) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      (sum_a_ff < ad32_pkg::ADLER_MOD) && (sum_b_ff < ad32_pkg::ADLER_MOD))
      else $error("running sum not reduced");

   a_checksum_matches_state: assert property (@(posedge clock) disable iff (reset)
      load_en |=> (rsp_ff.checksum == {sum_b_ff, sum_a_ff}))
      else $error("checksum differs from running sums");

   a_echo_matches_part: assert property (@(posedge clock) disable iff (reset)
      load_en |=> (rsp_ff.data_echo == $past(part.data)))
      else $error("echoed data differs from request data");

endmodule

`default_nettype wire

>>> src/adler32_wide_checksum_top.sv
// After acceptance a request passes the lane register, then the output register.
// Throughput: one request per cycle unless rsp_stall holds a full pipeline.
// The lane stage and the output register let a new request in while a result waits.
// Reset clears both stages, sets the running checksum to 1 and the seed to 1.
`default_nettype none

module adler32_wide_checksum_top #(
   parameter int unsigned BYTES_PER_ITEM = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire ad32_pkg::req_type  req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output ad32_pkg::rsp_type       rsp_payload,
   input  wire logic               csr_wr_en,
   input  wire logic [31:0]        csr_wr_data
);

   logic               seed_ff;
   logic [31:0]        csr_seed_ff;
   logic               s1_valid_ff;
   logic               rsp_valid_ff;
   logic               out_load;
   logic               s1_load;
   logic               req_accept;
   ad32_pkg::part_type part;

   assign out_load   = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || out_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;
   assign rsp_valid  = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_seed_ff <= 32'd1;
         seed_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         csr_seed_ff <= csr_wr_data;
         seed_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   ad32_lanes #(
      .NUM_LANES (BYTES_PER_ITEM)
   ) u_lanes (
      .clock       (clock),
      .load_en     (req_accept),
      .req_payload (req_payload),
      .part        (part)
   );

   ad32_state u_state (
      .clock       (clock),
      .reset       (reset),
      .load_en     (out_load && s1_valid_ff),
      .part        (part),
      .seed        (csr_seed_ff),
      .rsp_payload (rsp_payload)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> s1_valid_ff)
      else $error("lane stage dropped a request");

   a_seed_written: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (seed_ff && (csr_seed_ff == $past(csr_wr_data))))
      else $error("seed register not written");

endmodule

`default_nettype wire

>>> sim/adler32_wide_checksum_top_tb.sv
`timescale 1ns / 1ps

module adler32_wide_checksum_top_tb;

   localparam int unsigned ADLER_BASE = 65521;
   localparam int unsigned MAX_LANES = 8;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ad32_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ad32_pkg::rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   logic [31:0] seed_reg = 32'd1;
   logic [15:0] sum_a = 16'd1;
   logic [15:0] sum_b = 16'd0;
   ad32_pkg::rsp_type expected_sums_q[$];

   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left = 0;
   bit src_idle_on = 1'b0;
   bit sink_idle_on = 1'b0;

   adler32_wide_checksum_top #(
      .BYTES_PER_ITEM(MAX_LANES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic ad32_pkg::rsp_type advance_sums(input ad32_pkg::req_type r);
      ad32_pkg::rsp_type res;
      int unsigned lanes;
      int unsigned a;
      int unsigned b;
      int unsigned k;
      if (r.start_flag) begin
         sum_a = 16'(int'(seed_reg[15:0]) % ADLER_BASE);
         sum_b = 16'(int'(seed_reg[31:16]) % ADLER_BASE);
      end
      lanes = (r.byte_count > MAX_LANES) ? MAX_LANES : r.byte_count;
      a = sum_a;
      b = sum_b;
      for (k = 0; k < lanes; k++) begin
         a = (a + r.data_bytes[8*k +: 8]) % ADLER_BASE;
         b = (b + a) % ADLER_BASE;
      end
      sum_a = 16'(a);
      sum_b = 16'(b);
      res.checksum = {sum_b, sum_a};
      res.data_echo = r.data_bytes;
      return res;
   endfunction

   function automatic void note_mismatch(input string what, input logic [63:0] want,
                                         input logic [63:0] got);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("mismatch %0s at %0t: expected %h, got %h", what, $realtime, want, got);
      end
   endfunction

   always @(posedge clock) begin
      ad32_pkg::rsp_type want;
      bit moved;
      moved = 1'b0;
      if (!reset && rsp_valid && !rsp_stall) begin
         moved = 1'b1;
         if (expected_sums_q.size() == 0) begin
            note_mismatch("unexpected result", 64'd0, {32'd0, rsp_payload.checksum});
         end else begin
            want = expected_sums_q.pop_front();
            if (rsp_payload.checksum !== want.checksum) begin
               note_mismatch("checksum", {32'd0, want.checksum},
                             {32'd0, rsp_payload.checksum});
            end
            if (rsp_payload.data_echo !== want.data_echo) begin
               note_mismatch("data_echo", want.data_echo, rsp_payload.data_echo);
            end
         end
      end
      if (!reset && csr_wr_en) begin
         seed_reg = csr_wr_data;
      end
      if (!reset && req_valid && !req_stall) begin
         moved = 1'b1;
         expected_sums_q.push_back(advance_sums(req_payload));
      end

      if (sink_idle_on && stall_left == 0 && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 17);
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end

      if (moved) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_request(input logic [63:0] data, input logic [3:0] count,
                               input logic start);
      ad32_pkg::req_type r;
      int unsigned gap;
      r.data_bytes = data;
      r.byte_count = count;
      r.start_flag = start;
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (expected_sums_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] value);
      settle_pipeline();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_data();
      case ($urandom_range(0, 9))
         0: return '1;
         1: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [3:0] random_count();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) return 4'd0;
      if (pick == 1) return 4'($urandom_range(9, 15));
      if (pick < 10) return 4'd8;
      return 4'($urandom_range(1, 7));
   endfunction

   // The sums after reset must be used when no request has loaded the seed.
   task automatic test_reset_state();
      send_request(64'h0, 4'd1, 1'b0);
      send_request('1, 4'd8, 1'b0);
      send_request(64'hA5A5_5A5A_0F0F_F0F0, 4'd0, 1'b0);
   endtask

   // Every byte count, including zero and counts that saturate, with unused bytes set.
   task automatic test_byte_counts();
      int unsigned c;
      send_request(64'h0123_4567_89AB_CDEF, 4'd0, 1'b1);
      for (c = 0; c < 16; c++) begin
         send_request('1, 4'(c), 1'b0);
      end
      send_request(64'hFFFF_FFFF_FFFF_FF00, 4'd1, 1'b1);
      send_request(64'h8000_0000_0000_0001, 4'd3, 1'b0);
   endtask

   // Seed halves at zero, at the modulus and above it.
   task automatic test_seed_extremes();
      logic [31:0] seeds[5];
      int unsigned s;
      seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFF0_FFF1, 32'hFFF1_FFF0, 32'h0000_FFFF};
      for (s = 0; s < 5; s++) begin
         write_seed(seeds[s]);
         send_request('1, 4'd8, 1'b1);
         send_request(64'h0, 4'd0, 1'b0);
      end
      write_seed(32'd1);
   endtask

   task automatic test_random_streams(input int unsigned total);
      int unsigned sent;
      int unsigned run_len;
      int unsigned k;
      logic [31:0] seed;
      sent = 0;
      while (sent < total) begin
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 3))
               0: seed = 32'h0000_0001;
               1: seed = 32'hFFFF_FFFF;
               2: seed = {16'($urandom_range(65515, 65535)), 16'($urandom_range(65515, 65535))};
               default: seed = $urandom;
            endcase
            write_seed(seed);
         end
         src_idle_on = ($urandom_range(0, 3) != 0);
         sink_idle_on = ($urandom_range(0, 3) != 0);
         run_len = $urandom_range(1, 80);
         for (k = 0; k < run_len && sent < total; k++) begin
            send_request(random_data(), random_count(),
                         (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0));
            sent++;
         end
      end
   endtask

   task automatic test_back_to_back(input int unsigned total);
      int unsigned k;
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      for (k = 0; k < total; k++) begin
         send_request(random_data(), random_count(), (k == 0) || ($urandom_range(0, 49) == 0));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_byte_counts();
      test_seed_extremes();
      test_random_streams(1600);
      test_back_to_back(220);
      settle_pipeline();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_sums_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/ad32_pkg.sv
src/ad32_lane.sv
src/ad32_lanes.sv
src/ad32_state.sv
src/adler32_wide_checksum_top.sv
sim/adler32_wide_checksum_top_tb.sv
